// ===== sv/usbsr_pkg.sv =====
`default_nettype none
package usbsr_pkg;

  // result actions
  localparam logic [2:0] ACT_DATA        = 3'd0;
  localparam logic [2:0] ACT_EMPTY       = 3'd1;
  localparam logic [2:0] ACT_STATUS      = 3'd2;
  localparam logic [2:0] ACT_STATUS_ADDR = 3'd3;
  localparam logic [2:0] ACT_STALL       = 3'd4;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE      = 8'd1;
  localparam logic [7:0] DESC_CONFIG      = 8'd2;
  localparam logic [7:0] DESC_QUALIFIER   = 8'd6;
  localparam logic [7:0] DESC_OTHER_SPEED = 8'd7;

  // reply sources
  localparam logic [2:0] SRC_DEVICE      = 3'd0;
  localparam logic [2:0] SRC_CONFIG      = 3'd1;
  localparam logic [2:0] SRC_QUALIFIER   = 3'd2;
  localparam logic [2:0] SRC_OTHER_SPEED = 3'd3;
  localparam logic [2:0] SRC_ZERO        = 3'd4;
  localparam logic [2:0] SRC_ONE         = 3'd5;

  localparam int LEN_W = 5;

  localparam logic [LEN_W-1:0] SIZE_DEVICE    = 5'd18;
  localparam logic [LEN_W-1:0] SIZE_CONFIG    = 5'd25;
  localparam logic [LEN_W-1:0] SIZE_QUALIFIER = 5'd10;

  localparam logic [7:0] DEVICE_ROM [0:17] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64,
    8'hac, 8'h05, 8'h41, 8'h4c, 8'h00, 8'h01,
    8'd0, 8'd0, 8'd0, 8'd1
  };

  localparam logic [7:0] CONFIG_ROM [0:24] = '{
    8'd9, 8'd2, 8'd25, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h02, 8'h02, 8'h00, 8'h02, 8'd0
  };

  localparam logic [7:0] QUALIFIER_ROM [0:9] = '{
    8'd10, 8'd6, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'd1, 8'd0
  };

  localparam logic [7:0] OTHER_SPEED_ROM [0:24] = '{
    8'd9, 8'd7, 8'd25, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h02, 8'h02, 8'h40, 8'h00, 8'd0
  };

  // one classified setup packet
  typedef struct packed {
    logic             is_data;
    logic [2:0]       src;
    logic [LEN_W-1:0] len;
    logic [2:0]       action;
    logic [6:0]       addr;
    logic             done;
  } cmd_t;

  function automatic logic [7:0] rom_byte(input logic [2:0] src,
                                          input logic [LEN_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (src)
      SRC_DEVICE:      b = DEVICE_ROM[idx];
      SRC_CONFIG:      b = CONFIG_ROM[idx];
      SRC_QUALIFIER:   b = QUALIFIER_ROM[idx[3:0]];
      SRC_OTHER_SPEED: b = OTHER_SPEED_ROM[idx];
      SRC_ONE:         b = 8'd1;
      default:         b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/usbsr_classify.sv =====
`default_nettype none
module usbsr_classify (
  input  wire logic [7:0]  setup_type,
  input  wire logic [7:0]  request_code,
  input  wire logic [7:0]  value_high,
  input  wire logic [7:0]  value_low,
  input  wire logic [15:0] max_reply_length,
  output usbsr_pkg::cmd_t  cmd
);
  import usbsr_pkg::*;

  logic             data_req;
  logic [2:0]       src;
  logic [LEN_W-1:0] size;

  always_comb begin
    cmd      = '0;
    data_req = 1'b0;
    src      = SRC_ZERO;
    size     = '0;
    if (setup_type[7]) begin
      case (request_code)
        REQ_GET_DESCRIPTOR: begin
          case (value_high)
            DESC_DEVICE: begin
              data_req = 1'b1; src = SRC_DEVICE; size = SIZE_DEVICE;
            end
            DESC_CONFIG: begin
              data_req = 1'b1; src = SRC_CONFIG; size = SIZE_CONFIG;
            end
            DESC_QUALIFIER: begin
              data_req = 1'b1; src = SRC_QUALIFIER; size = SIZE_QUALIFIER;
            end
            DESC_OTHER_SPEED: begin
              data_req = 1'b1; src = SRC_OTHER_SPEED; size = SIZE_CONFIG;
            end
            default: cmd.action = ACT_STALL;
          endcase
        end
        REQ_GET_STATUS: begin
          data_req = 1'b1; src = SRC_ZERO; size = 5'd2;
        end
        REQ_GET_CONFIGURATION: begin
          data_req = 1'b1; src = SRC_ONE; size = 5'd1;
        end
        REQ_GET_INTERFACE: begin
          data_req = 1'b1; src = SRC_ZERO; size = 5'd1;
        end
        default: cmd.action = ACT_STALL;
      endcase
    end else begin
      case (request_code)
        REQ_SET_ADDRESS: begin
          cmd.action = ACT_STATUS_ADDR;
          cmd.addr   = value_low[6:0];
        end
        REQ_SET_CONFIGURATION: begin
          cmd.action = ACT_STATUS;
          cmd.done   = 1'b1;
        end
        REQ_SET_INTERFACE: cmd.action = ACT_STATUS;
        default:           cmd.action = ACT_STALL;
      endcase
    end
    cmd.is_data = data_req;
    cmd.src     = src;
    // cut the reply to wLength
    if (max_reply_length < {{(16-LEN_W){1'b0}}, size}) begin
      cmd.len = max_reply_length[LEN_W-1:0];
    end else begin
      cmd.len = size;
    end
  end

endmodule
`default_nettype wire

// ===== sv/usbsr_queue.sv =====
`default_nettype none
module usbsr_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire usbsr_pkg::cmd_t push_cmd,
  input  wire logic       pop,
  output usbsr_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);
  import usbsr_pkg::*;

  cmd_t       entry [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/usbsr_emitter.sv =====
`default_nettype none
module usbsr_emitter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire usbsr_pkg::cmd_t head,
  input  wire logic       empty,
  output logic            pop,
  output logic            strobe,
  output logic [2:0]      action,
  output logic [7:0]      data_byte,
  output logic [6:0]      device_address,
  output logic            enumeration_done,
  output logic            last_of_reply
);
  import usbsr_pkg::*;

  cmd_t             cur;
  logic             active;
  logic [LEN_W-1:0] idx;
  logic             last_now;
  logic             take;

  always_comb begin
    if (cur.is_data && (cur.len != '0)) begin
      last_now = (idx == cur.len - 5'd1);
    end else begin
      last_now = 1'b1;
    end
  end

  assign take = (!active || last_now) && !empty;
  assign pop  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (take) begin
        active <= 1'b1;
      end else if (last_now) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head;
      idx <= '0;
    end else begin
      idx <= idx + 5'd1;
    end
    // result registers
    last_of_reply <= last_now;
    if (cur.is_data) begin
      device_address   <= 7'd0;
      enumeration_done <= 1'b0;
      if (cur.len == '0) begin
        action    <= ACT_EMPTY;
        data_byte <= 8'h00;
      end else begin
        action    <= ACT_DATA;
        data_byte <= rom_byte(cur.src, idx);
      end
    end else begin
      action           <= cur.action;
      data_byte        <= 8'h00;
      device_address   <= cur.addr;
      enumeration_done <= cur.done;
    end
  end

endmodule
`default_nettype wire

// ===== sv/usb_standard_request_responder.sv =====
`default_nettype none
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// setup in  | start high, busy low | setup_type, request_code, value_high,
//           |                      | value_low, max_reply_length
// result    | strobe high 1 cycle  | action, data_byte, device_address,
//           |                      | enumeration_done, last_of_reply
//
// one result per cycle: a setup packet gives 1 to 25 results of the emitter,
// set by the reply length (min of descriptor size and wLength, at least one)
// a setup passes the queue, the emitter's current command and the result registers;
// the two-entry queue lets the next packets be taken while a reply is still going out
// busy is high only when the queue holds two packets
// synchronous reset clears the queue and the emitter; results cannot be stalled
module usb_standard_request_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  setup_type,
  input  wire logic [7:0]  request_code,
  input  wire logic [7:0]  value_high,
  input  wire logic [7:0]  value_low,
  input  wire logic [15:0] max_reply_length,
  output logic             strobe,
  output logic [2:0]       action,
  output logic [7:0]       data_byte,
  output logic [6:0]       device_address,
  output logic             enumeration_done,
  output logic             last_of_reply
);
  import usbsr_pkg::*;

  cmd_t new_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  // front: decode the setup packet into a reply command
  usbsr_classify u_classify (
    .setup_type       (setup_type),
    .request_code     (request_code),
    .value_high       (value_high),
    .value_low        (value_low),
    .max_reply_length (max_reply_length),
    .cmd              (new_cmd)
  );

  assign busy = full;
  assign push = start && !full;

  // decouples the decoder from the byte emitter
  usbsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (new_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // back: steps through the reply, one result per cycle
  usbsr_emitter u_emitter (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .strobe           (strobe),
    .action           (action),
    .data_byte        (data_byte),
    .device_address   (device_address),
    .enumeration_done (enumeration_done),
    .last_of_reply    (last_of_reply)
  );

endmodule
`default_nettype wire

// ===== bench/usbsr_reply_checker.sv =====
module usbsr_reply_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [7:0]  setup_type,
  input  wire logic [7:0]  request_code,
  input  wire logic [7:0]  value_high,
  input  wire logic [7:0]  value_low,
  input  wire logic [15:0] max_reply_length,
  input  wire logic        strobe,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [6:0]  device_address,
  input  wire logic        enumeration_done,
  input  wire logic        last_of_reply,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import usbsr_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic [6:0] addr;
    logic       done;
    logic       last;
  } reply_t;

  typedef enum logic [2:0] {
    REPLY_NONE,
    REPLY_DEVICE,
    REPLY_CONFIG,
    REPLY_QUALIFIER,
    REPLY_OTHER_SPEED,
    REPLY_ZEROS,
    REPLY_ONE
  } reply_src_t;

  // descriptor contents, little-endian, chapter 9 layout
  localparam logic [7:0] DEVICE_DESC [18] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64,
    8'hac, 8'h05, 8'h41, 8'h4c, 8'h00, 8'h01,
    8'd0, 8'd0, 8'd0, 8'd1
  };
  localparam logic [7:0] CONFIG_DESC [25] = '{
    8'd9, 8'd2, 8'd25, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h02, 8'h02, 8'h00, 8'h02, 8'd0
  };
  localparam logic [7:0] QUALIFIER_DESC [10] = '{
    8'd10, 8'd6, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'd1, 8'd0
  };
  localparam logic [7:0] OTHER_SPEED_DESC [25] = '{
    8'd9, 8'd7, 8'd25, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h02, 8'h02, 8'h40, 8'h00, 8'd0
  };

  reply_t expected_replies[$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic logic [7:0] descriptor_byte(input reply_src_t src, input int idx);
    case (src)
      REPLY_DEVICE:      return DEVICE_DESC[idx];
      REPLY_CONFIG:      return CONFIG_DESC[idx];
      REPLY_QUALIFIER:   return QUALIFIER_DESC[idx];
      REPLY_OTHER_SPEED: return OTHER_SPEED_DESC[idx];
      REPLY_ONE:         return 8'd1;
      default:           return 8'h00;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic predict_reply(input logic [7:0] rtype, input logic [7:0] code,
                               input logic [7:0] vhigh, input logic [7:0] vlow,
                               input logic [15:0] wlen);
    reply_src_t src;
    int size;
    int n;
    reply_t r;
    src = REPLY_NONE;
    size = 0;
    r = '0;
    r.last = 1'b1;
    if (rtype[7]) begin
      case (code)
        REQ_GET_DESCRIPTOR: begin
          case (vhigh)
            DESC_DEVICE:      begin src = REPLY_DEVICE;      size = 18; end
            DESC_CONFIG:      begin src = REPLY_CONFIG;      size = 25; end
            DESC_QUALIFIER:   begin src = REPLY_QUALIFIER;   size = 10; end
            DESC_OTHER_SPEED: begin src = REPLY_OTHER_SPEED; size = 25; end
            default: ;
          endcase
        end
        REQ_GET_STATUS:        begin src = REPLY_ZEROS; size = 2; end
        REQ_GET_CONFIGURATION: begin src = REPLY_ONE;   size = 1; end
        REQ_GET_INTERFACE:     begin src = REPLY_ZEROS; size = 1; end
        default: ;
      endcase
    end
    if (src != REPLY_NONE) begin
      n = (int'(wlen) < size) ? int'(wlen) : size;
      if (n == 0) begin
        // nothing left after the cut: one empty data stage
        r.action = ACT_EMPTY;
        expected_replies.push_back(r);
      end else begin
        for (int i = 0; i < n; i++) begin
          r.action = ACT_DATA;
          r.data = descriptor_byte(src, i);
          r.last = (i == n - 1);
          expected_replies.push_back(r);
        end
      end
    end else begin
      r.action = ACT_STALL;
      if (!rtype[7]) begin
        case (code)
          REQ_SET_ADDRESS: begin
            r.action = ACT_STATUS_ADDR;
            r.addr = vlow[6:0];
          end
          REQ_SET_CONFIGURATION: begin
            r.action = ACT_STATUS;
            r.done = 1'b1;
          end
          REQ_SET_INTERFACE: r.action = ACT_STATUS;
          default: ;
        endcase
      end
      expected_replies.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst) begin
      if (strobe) begin
        got = {action, data_byte, device_address, enumeration_done, last_of_reply};
        if (expected_replies.size() == 0) begin
          report_mismatch("action of result with none pending", 0, got.action);
        end else begin
          want = expected_replies.pop_front();
          if (got.action != want.action) report_mismatch("action", want.action, got.action);
          if (got.data != want.data) report_mismatch("data_byte", want.data, got.data);
          if (got.addr != want.addr) report_mismatch("device_address", want.addr, got.addr);
          if (got.done != want.done)
            report_mismatch("enumeration_done", want.done, got.done);
          if (got.last != want.last) report_mismatch("last_of_reply", want.last, got.last);
        end
      end
      if (start && !busy)
        predict_reply(setup_type, request_code, value_high, value_low, max_reply_length);
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import usbsr_pkg::*;

  // bmRequestType direction and codes the block does not know
  localparam logic [7:0] DIR_IN        = 8'h80;
  localparam logic [7:0] DIR_OUT       = 8'h00;
  localparam logic [7:0] REQ_UNDEFINED = 8'hff;
  localparam logic [7:0] DESC_NONE     = 8'd0;
  localparam logic [7:0] DESC_STRING   = 8'd3;

  // generous: every transfer at 25 results plus long sender gaps, many times over
  localparam int CYCLE_LIMIT = 200000;
  // tail after the last result: first-result latency plus a full reply and the queue
  localparam int TAIL_CYCLES = 60;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  setup_type;
  logic [7:0]  request_code;
  logic [7:0]  value_high;
  logic [7:0]  value_low;
  logic [15:0] max_reply_length;
  logic        strobe;
  logic [2:0]  action;
  logic [7:0]  data_byte;
  logic [6:0]  device_address;
  logic        enumeration_done;
  logic        last_of_reply;

  int mismatches;
  int outstanding;
  int cycles;
  int sender_idle_pct;

  usb_standard_request_responder u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .setup_type       (setup_type),
    .request_code     (request_code),
    .value_high       (value_high),
    .value_low        (value_low),
    .max_reply_length (max_reply_length),
    .strobe           (strobe),
    .action           (action),
    .data_byte        (data_byte),
    .device_address   (device_address),
    .enumeration_done (enumeration_done),
    .last_of_reply    (last_of_reply)
  );

  // watches both channels, predicts each reply and compares
  usbsr_reply_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .setup_type       (setup_type),
    .request_code     (request_code),
    .value_high       (value_high),
    .value_low        (value_low),
    .max_reply_length (max_reply_length),
    .strobe           (strobe),
    .action           (action),
    .data_byte        (data_byte),
    .device_address   (device_address),
    .enumeration_done (enumeration_done),
    .last_of_reply    (last_of_reply),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung block or a lost result ends here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("usb_standard_request_responder test failed");
      $finish;
    end
  end

  // one setup transfer; entered and left at a falling edge
  task automatic send_setup(input logic [7:0] rtype, input logic [7:0] code,
                            input logic [7:0] vhigh, input logic [7:0] vlow,
                            input logic [15:0] wlen);
    // random gaps before the transfer, with junk on the payload while start is low
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      setup_type = 8'($urandom);
      request_code = 8'($urandom);
      value_high = 8'($urandom);
      value_low = 8'($urandom);
      max_reply_length = 16'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    setup_type = rtype;
    request_code = code;
    value_high = vhigh;
    value_low = vlow;
    max_reply_length = wlen;
    // the transfer happens at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold the sender off until every predicted result has been seen
  task automatic drain_replies();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // mostly well-formed setups with random content, the rest pure noise
  task automatic run_phase(input int count);
    logic [7:0]  rt;
    logic [7:0]  rc;
    logic [7:0]  vh;
    logic [7:0]  vl;
    logic [15:0] wl;
    int          pick;
    for (int k = 0; k < count; k++) begin
      rt = 8'($urandom);
      rc = 8'($urandom);
      vh = 8'($urandom);
      vl = 8'($urandom);
      case ($urandom_range(9))
        0:       wl = 16'd0;
        1:       wl = 16'hffff;
        2, 3:    wl = 16'($urandom);
        default: wl = 16'($urandom_range(30));
      endcase
      pick = int'($urandom_range(99));
      if (pick < 45) begin
        // descriptor reads, now and then of an unknown type
        rt[7] = 1'b1;
        rc = REQ_GET_DESCRIPTOR;
        case ($urandom_range(4))
          0:       vh = DESC_DEVICE;
          1:       vh = DESC_CONFIG;
          2:       vh = DESC_QUALIFIER;
          3:       vh = DESC_OTHER_SPEED;
          default: ;
        endcase
      end else if (pick < 60) begin
        rt[7] = 1'b1;
        case ($urandom_range(2))
          0:       rc = REQ_GET_STATUS;
          1:       rc = REQ_GET_CONFIGURATION;
          default: rc = REQ_GET_INTERFACE;
        endcase
      end else if (pick < 85) begin
        rt[7] = 1'b0;
        case ($urandom_range(2))
          0:       rc = REQ_SET_ADDRESS;
          1:       rc = REQ_SET_CONFIGURATION;
          default: rc = REQ_SET_INTERFACE;
        endcase
      end
      send_setup(rt, rc, vh, vl, wl);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    setup_type = '0;
    request_code = '0;
    value_high = '0;
    value_low = '0;
    max_reply_length = '0;
    sender_idle_pct = 37;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every descriptor in full, and all but the qualifier cut short
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'h00, 16'hffff);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'hff, 16'd18);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'h00, 16'd1);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_CONFIG, 8'h00, 16'hffff);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_CONFIG, 8'h00, 16'd9);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_QUALIFIER, 8'h00, 16'd64);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_OTHER_SPEED, 8'h00, 16'd25);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_OTHER_SPEED, 8'h00, 16'd24);
    // reply cut to nothing gives an empty data stage
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'h00, 16'd0);
    send_setup(DIR_IN, REQ_GET_INTERFACE, 8'h00, 8'h00, 16'd0);
    // type and recipient bits other than direction make no difference
    send_setup(8'hff, REQ_GET_DESCRIPTOR, DESC_QUALIFIER, 8'h00, 16'h8000);
    // unknown descriptor types stall
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_NONE, 8'h00, 16'd64);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, DESC_STRING, 8'h00, 16'd64);
    send_setup(DIR_IN, REQ_GET_DESCRIPTOR, 8'hff, 8'h00, 16'd64);
    // the short reads
    send_setup(DIR_IN, REQ_GET_STATUS, 8'h00, 8'h00, 16'd2);
    send_setup(DIR_IN, REQ_GET_STATUS, 8'h00, 8'h00, 16'd1);
    send_setup(DIR_IN, REQ_GET_CONFIGURATION, 8'h00, 8'h00, 16'hffff);
    send_setup(DIR_IN, REQ_GET_INTERFACE, 8'h00, 8'h00, 16'd1);
    // unknown codes stall either way, as do sets marked IN and gets marked OUT
    send_setup(DIR_IN, REQ_UNDEFINED, 8'h00, 8'h00, 16'd64);
    send_setup(DIR_IN, REQ_SET_ADDRESS, 8'h00, 8'h7f, 16'd0);
    send_setup(8'h7f, REQ_UNDEFINED, 8'hff, 8'hff, 16'hffff);
    send_setup(DIR_OUT, REQ_GET_DESCRIPTOR, DESC_DEVICE, 8'h00, 16'd64);
    // host-to-device: address with its top bit dropped, address zero, config, interface
    send_setup(DIR_OUT, REQ_SET_ADDRESS, 8'h00, 8'hff, 16'd0);
    send_setup(DIR_OUT, REQ_SET_ADDRESS, 8'hff, 8'h00, 16'hffff);
    send_setup(8'h7f, REQ_SET_CONFIGURATION, 8'h00, 8'h01, 16'd0);
    send_setup(DIR_OUT, REQ_SET_INTERFACE, 8'h00, 8'h00, 16'd0);

    run_phase(45);
    drain_replies();

    // slower sender
    sender_idle_pct = 56;
    run_phase(50);
    drain_replies();

    // back-to-back transfers so the queue fills and busy comes into play
    sender_idle_pct = 0;
    run_phase(50);
    drain_replies();

    // anything arriving now is a result nobody asked for
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("usb_standard_request_responder test passed");
    end else begin
      $display("usb_standard_request_responder test failed");
    end
    $finish;
  end

endmodule
